// ----- rtl/ate_pkg.sv -----
package ate_pkg;

    localparam int SCREEN_ROWS          = 24;
    localparam int SCREEN_COLUMNS       = 80;
    localparam int HISTORY_LINES        = 256;
    localparam int MAX_SEQUENCE_NUMBERS = 8;

    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int SLOT_W = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
    localparam int USED_W = $clog2(HISTORY_LINES + 1);
    localparam int CNT_W  = $clog2(MAX_SEQUENCE_NUMBERS + 1);
    localparam int NIDX_W = $clog2(MAX_SEQUENCE_NUMBERS);
    localparam int SCR_AW  = $clog2(SCREEN_ROWS * SCREEN_COLUMNS);
    localparam int HIST_AW = $clog2(HISTORY_LINES * SCREEN_COLUMNS);

    localparam logic [7:0] STYLE_DEFAULT = 8'h07;

    localparam logic [1:0] FUNC_FEED      = 2'd0;
    localparam logic [1:0] FUNC_VIEW_UP   = 2'd1;
    localparam logic [1:0] FUNC_VIEW_DOWN = 2'd2;
    localparam logic [1:0] FUNC_READ      = 2'd3;

    localparam logic [7:0] BYTE_BEL    = 8'h07;
    localparam logic [7:0] BYTE_BS     = 8'h08;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_TILDE  = 8'h7E;
    localparam logic [7:0] BYTE_LBRACK = 8'h5B;
    localparam logic [7:0] BYTE_RBRACK = 8'h5D;
    localparam logic [7:0] BYTE_LPAREN = 8'h28;
    localparam logic [7:0] BYTE_RPAREN = 8'h29;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_SEMI   = 8'h3B;
    localparam logic [7:0] BYTE_ZERO   = 8'h30;
    localparam logic [7:0] BYTE_NINE   = 8'h39;
    localparam logic [7:0] BYTE_FINAL_LO = 8'h40;

    localparam logic [7:0] CMD_SGR   = 8'h6D;
    localparam logic [7:0] CMD_POS_H = 8'h48;
    localparam logic [7:0] CMD_POS_F = 8'h66;
    localparam logic [7:0] CMD_UP    = 8'h41;
    localparam logic [7:0] CMD_DOWN  = 8'h42;
    localparam logic [7:0] CMD_RIGHT = 8'h43;
    localparam logic [7:0] CMD_LEFT  = 8'h44;
    localparam logic [7:0] CMD_ED    = 8'h4A;
    localparam logic [7:0] CMD_EL    = 8'h4B;

    typedef struct packed {
        logic              scr_re;
        logic [ROW_W-1:0]  scr_rrow;
        logic [COL_W-1:0]  scr_rcol;
        logic              scr_we;
        logic [ROW_W-1:0]  scr_wrow;
        logic [COL_W-1:0]  scr_wcol;
        logic [15:0]       scr_wdata;
        logic              hist_re;
        logic [SLOT_W-1:0] hist_slot;
        logic [COL_W-1:0]  hist_col;
        logic              hist_copy;
    } mem_req_t;

    typedef struct packed {
        logic [7:0]       cell_character;
        logic [7:0]       cell_style;
        logic             view_moved;
        logic [ROW_W-1:0] cursor_row_now;
        logic [COL_W-1:0] cursor_column_now;
    } result_t;

endpackage

// ----- rtl/ansi_terminal_screen_engine_top.sv -----
// Text terminal screen engine.
// Input stream (s_*): one word per request. s_tuser carries func: feed a byte,
// scroll the view up or down into history, or read one cell of the view.
// Output stream (m_*): exactly one result word per request, carrying the cell
// read (zero unless a read), the view-moved flag and the cursor after the request.
// Sequence: a request is taken in idle, executed in the EXEC state and its
// result is registered. Plain bytes, view scrolls and reads go straight from
// EXEC to the result; a CSI command adds the CMD state, an SGR list one SGR
// step per parameter, a line clear one step per cleared cell, a screen scroll
// a sweep of the top row, one cell per cycle (each cell read for the history
// ring and blanked), an erase of the whole screen a sweep of every cell.
// One request is in flight at a time; s_tready is high only when idle, so a
// new request waits until the last result has entered the output register.
// Reset: control state clears at once, then the screen store is swept blank
// with s_tready low. History lines are never cleared.
// Stall: a result waits in the output register while m_tready is low; a
// further request is still taken, and its result waits in RESP meanwhile.
module ansi_terminal_screen_engine_top
    import ate_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] data_byte, [16:8] scroll_lines, [24:17] view_row, [32:25] view_column
    input  logic [39:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] cell_character, [15:8] cell_style, [16] view_moved,
    // [21:17] cursor_row_now, [28:22] cursor_column_now
    output logic [31:0] m_tdata
);

    mem_req_t    req;
    logic [15:0] mem_rdata;
    result_t     res;
    logic        res_valid;
    logic        res_ready;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    // result register frees the sequencer once the word is parked here
    assign res_ready = !m_tvalid_reg || m_tready;

    ate_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_byte   (s_tdata[7:0]),
        .in_lines  (s_tdata[16:8]),
        .in_vrow   (s_tdata[24:17]),
        .in_vcol   (s_tdata[32:25]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .req       (req),
        .mem_rdata (mem_rdata)
    );

    ate_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {3'd0, res.cursor_column_now, res.cursor_row_now,
                            res.view_moved, res.cell_style, res.cell_character};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/ate_store.sv -----
module ate_store
    import ate_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output logic [15:0] rdata
);

    logic [15:0] scr_mem  [SCREEN_ROWS*SCREEN_COLUMNS];
    logic [15:0] hist_mem [HISTORY_LINES*SCREEN_COLUMNS];

    logic [SCR_AW-1:0]  scr_raddr;
    logic [SCR_AW-1:0]  scr_waddr;
    logic [HIST_AW-1:0] hist_addr;
    logic [15:0]        scr_rdata_reg;
    logic [15:0]        hist_rdata_reg;
    logic               rd_hist_reg;
    logic               copy_reg;
    logic [HIST_AW-1:0] copy_addr_reg;

    assign scr_raddr = SCR_AW'(req.scr_rrow) * SCR_AW'(SCREEN_COLUMNS) + SCR_AW'(req.scr_rcol);
    assign scr_waddr = SCR_AW'(req.scr_wrow) * SCR_AW'(SCREEN_COLUMNS) + SCR_AW'(req.scr_wcol);
    assign hist_addr = HIST_AW'(req.hist_slot) * HIST_AW'(SCREEN_COLUMNS)
                     + HIST_AW'(req.hist_col);

    always_ff @(posedge clk)
    begin
        if (req.scr_we)
        begin
            scr_mem[scr_waddr] <= req.scr_wdata;
        end
        if (req.scr_re)
        begin
            scr_rdata_reg <= scr_mem[scr_raddr];
        end
    end

    // row copy: cell read last cycle lands in history now
    always_ff @(posedge clk)
    begin
        if (copy_reg)
        begin
            hist_mem[copy_addr_reg] <= scr_rdata_reg;
        end
        if (req.hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_addr];
        end
        copy_addr_reg <= hist_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hist_reg <= 1'b0;
            copy_reg    <= 1'b0;
        end
        else
        begin
            copy_reg <= req.hist_copy;
            if (req.scr_re || req.hist_re)
            begin
                rd_hist_reg <= req.hist_re;
            end
        end
    end

    assign rdata = rd_hist_reg ? hist_rdata_reg : scr_rdata_reg;

endmodule

// ----- rtl/ate_ctrl.sv -----
module ate_ctrl
    import ate_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_func,
    input  logic [7:0]  in_byte,
    input  logic [8:0]  in_lines,
    input  logic [7:0]  in_vrow,
    input  logic [7:0]  in_vcol,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res,
    output mem_req_t    req,
    input  logic [15:0] mem_rdata
);

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_EXEC   = 9'b000000100,
        ST_CMD    = 9'b000001000,
        ST_SGR    = 9'b000010000,
        ST_SCROLL = 9'b000100000,
        ST_KCLR   = 9'b001000000,
        ST_RESP   = 9'b010000000,
        ST_SPARE  = 9'b100000000
    } state_t;

    typedef enum logic [5:0] {
        PM_NORMAL  = 6'b000001,
        PM_ESCAPE  = 6'b000010,
        PM_CSI     = 6'b000100,
        PM_OSC     = 6'b001000,
        PM_OSC_ESC = 6'b010000,
        PM_SKIP    = 6'b100000
    } parse_t;

    state_t state_reg, state_next;
    parse_t pmode_reg, pmode_next;

    logic [1:0]  func_reg;
    logic [7:0]  byte_reg;
    logic [8:0]  lines_reg;
    logic [7:0]  vrow_reg;
    logic [7:0]  vcol_reg;

    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [7:0]        style_reg, style_next;
    logic [15:0]       nums_reg [MAX_SEQUENCE_NUMBERS];
    logic [15:0]       nums_next [MAX_SEQUENCE_NUMBERS];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       acc_reg, acc_next;
    logic              seen_reg, seen_next;
    logic [SLOT_W-1:0] first_reg, first_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [USED_W-1:0] voff_reg, voff_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ROW_W-1:0]  sw_row_reg, sw_row_next;
    logic [COL_W-1:0]  sw_col_reg, sw_col_next;
    logic [COL_W-1:0]  sw_last_reg, sw_last_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [NIDX_W-1:0] sgr_idx_reg, sgr_idx_next;
    logic              moved_reg, moved_next;
    logic              blank_reg, blank_next;
    logic              init_reg, init_next;

    // scratch values of the sequencer
    logic [15:0]       mode_num;
    logic [15:0]       num0;
    logic [15:0]       num1;
    logic [15:0]       amount;
    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W:0]    abs_sum;
    logic [USED_W:0]   abs_line;
    logic [USED_W:0]   lines_room;
    logic [USED_W:0]   off_sum;
    logic [SLOT_W:0]   slot_sum;
    logic [COL_W:0]    tab_next;
    logic [USED_W-1:0] used_lf;
    logic [15:0]       acc_times;
    logic              csi_final;

    function automatic logic [ROW_W-1:0] to_phys(input logic [ROW_W-1:0] lr,
                                                 input logic [ROW_W-1:0] top);
        logic [ROW_W:0] s;
        s = {1'b0, lr} + {1'b0, top};
        if (s >= (ROW_W+1)'(SCREEN_ROWS))
        begin
            s = s - (ROW_W+1)'(SCREEN_ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [7:0] sgr_apply(input logic [7:0] s, input logic [15:0] p);
        logic [3:0] fg;
        logic [3:0] bg;
        fg = s[3:0];
        bg = s[7:4];
        if (p == 16'd0)
        begin
            fg = 4'd7;
            bg = 4'd0;
        end
        else if (p == 16'd1 && fg < 4'd8)
            fg = fg + 4'd8;
        else if (p == 16'd22 && fg >= 4'd8)
            fg = fg - 4'd8;
        else if (p >= 16'd30 && p <= 16'd37)
            fg = 4'(p - 16'd30);
        else if (p == 16'd39)
            fg = 4'd7;
        else if (p >= 16'd40 && p <= 16'd47)
            bg = 4'(p - 16'd40);
        else if (p == 16'd49)
            bg = 4'd0;
        else if (p >= 16'd90 && p <= 16'd97)
            fg = 4'(p - 16'd82);
        else if (p >= 16'd100 && p <= 16'd107)
            bg = 4'(p - 16'd92);
        return {bg, fg};
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);

    assign res.cell_character    = (func_reg == FUNC_READ && !blank_reg) ? mem_rdata[7:0] : 8'd0;
    assign res.cell_style        = (func_reg == FUNC_READ && !blank_reg) ? mem_rdata[15:8] : 8'd0;
    assign res.view_moved        = moved_reg;
    assign res.cursor_row_now    = cur_row_reg;
    assign res.cursor_column_now = cur_col_reg;

    assign cur_phys = to_phys(cur_row_reg, top_reg);
    assign mode_num = (cnt_reg == '0) ? 16'd0 : nums_reg[0];
    assign num0 = (cnt_reg > CNT_W'(0) && nums_reg[0] != 16'd0) ? nums_reg[0] : 16'd1;
    assign num1 = (cnt_reg > CNT_W'(1) && nums_reg[1] != 16'd0) ? nums_reg[1] : 16'd1;
    assign acc_times = (acc_reg << 3) + (acc_reg << 1) + 16'(byte_reg - BYTE_ZERO);
    assign csi_final = (byte_reg >= BYTE_FINAL_LO) && (byte_reg <= BYTE_TILDE);
    assign tab_next  = ({1'b0, cur_col_reg} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);

    always_comb
    begin
        state_next   = state_reg;
        pmode_next   = pmode_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        style_next   = style_reg;
        nums_next    = nums_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        seen_next    = seen_reg;
        first_next   = first_reg;
        used_next    = used_reg;
        voff_next    = voff_reg;
        top_next     = top_reg;
        sw_row_next  = sw_row_reg;
        sw_col_next  = sw_col_reg;
        sw_last_next = sw_last_reg;
        slot_next    = slot_reg;
        sgr_idx_next = sgr_idx_reg;
        moved_next   = moved_reg;
        blank_next   = blank_reg;
        init_next    = init_reg;
        req          = '0;
        amount       = num0;
        abs_sum      = '0;
        abs_line     = '0;
        lines_room   = '0;
        off_sum      = '0;
        slot_sum     = '0;
        used_lf      = used_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                req.scr_we   = 1'b1;
                req.scr_wrow = sw_row_reg;
                req.scr_wcol = sw_col_reg;
                if (sw_col_reg == COL_W'(SCREEN_COLUMNS - 1))
                begin
                    sw_col_next = '0;
                    sw_row_next = sw_row_reg + ROW_W'(1);
                    if (sw_row_reg == ROW_W'(SCREEN_ROWS - 1))
                    begin
                        sw_row_next = '0;
                        init_next   = 1'b0;
                        state_next  = init_reg ? ST_IDLE : ST_RESP;
                    end
                end
                else
                begin
                    sw_col_next = sw_col_reg + COL_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    moved_next = 1'b0;
                    blank_next = 1'b0;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_RESP;
                case (func_reg)
                    FUNC_FEED:
                    begin
                        unique case (pmode_reg)
                            PM_ESCAPE:
                            begin
                                if (byte_reg == BYTE_LBRACK)
                                begin
                                    pmode_next = PM_CSI;
                                    for (int i = 0; i < MAX_SEQUENCE_NUMBERS; i++)
                                    begin
                                        nums_next[i] = 16'd0;
                                    end
                                    cnt_next  = '0;
                                    acc_next  = 16'd0;
                                    seen_next = 1'b0;
                                end
                                else if (byte_reg == BYTE_RBRACK)
                                    pmode_next = PM_OSC;
                                else if (byte_reg == BYTE_LPAREN || byte_reg == BYTE_RPAREN)
                                    pmode_next = PM_SKIP;
                                else
                                    pmode_next = PM_NORMAL;
                            end
                            PM_OSC:
                            begin
                                if (byte_reg == BYTE_BEL)
                                    pmode_next = PM_NORMAL;
                                else if (byte_reg == BYTE_ESC)
                                    pmode_next = PM_OSC_ESC;
                            end
                            PM_OSC_ESC:
                            begin
                                pmode_next = (byte_reg == BYTE_BSLASH || byte_reg == BYTE_BEL)
                                           ? PM_NORMAL : PM_OSC;
                            end
                            PM_SKIP:
                            begin
                                pmode_next = PM_NORMAL;
                            end
                            PM_CSI:
                            begin
                                if (byte_reg >= BYTE_ZERO && byte_reg <= BYTE_NINE)
                                begin
                                    seen_next = 1'b1;
                                    acc_next  = acc_times;
                                end
                                else if (byte_reg == BYTE_SEMI)
                                begin
                                    if (cnt_reg < CNT_W'(MAX_SEQUENCE_NUMBERS))
                                    begin
                                        nums_next[cnt_reg[NIDX_W-1:0]] = seen_reg ? acc_reg : 16'd0;
                                        cnt_next = cnt_reg + CNT_W'(1);
                                    end
                                    acc_next  = 16'd0;
                                    seen_next = 1'b0;
                                end
                                else if (csi_final)
                                begin
                                    if (cnt_reg < CNT_W'(MAX_SEQUENCE_NUMBERS)
                                        && (seen_reg || cnt_reg == '0))
                                    begin
                                        nums_next[cnt_reg[NIDX_W-1:0]] = seen_reg ? acc_reg : 16'd0;
                                        cnt_next = cnt_reg + CNT_W'(1);
                                    end
                                    pmode_next = PM_NORMAL;
                                    state_next = ST_CMD;
                                end
                            end
                            default:
                            begin
                                if (byte_reg == BYTE_ESC)
                                    pmode_next = PM_ESCAPE;
                                else if (byte_reg == BYTE_CR)
                                    cur_col_next = '0;
                                else if (byte_reg == BYTE_BS)
                                begin
                                    if (cur_col_reg != '0)
                                        cur_col_next = cur_col_reg - COL_W'(1);
                                end
                                else if (byte_reg == BYTE_TAB)
                                begin
                                    cur_col_next = (tab_next < (COL_W+1)'(SCREEN_COLUMNS))
                                                 ? tab_next[COL_W-1:0]
                                                 : COL_W'(SCREEN_COLUMNS - 1);
                                end
                                else if (byte_reg == BYTE_LF
                                         || (byte_reg >= BYTE_SPACE && byte_reg <= BYTE_TILDE))
                                begin
                                    if (byte_reg != BYTE_LF)
                                    begin
                                        req.scr_we    = 1'b1;
                                        req.scr_wrow  = cur_phys;
                                        req.scr_wcol  = cur_col_reg;
                                        req.scr_wdata = {style_reg, byte_reg};
                                    end
                                    if (byte_reg != BYTE_LF
                                        && cur_col_reg != COL_W'(SCREEN_COLUMNS - 1))
                                    begin
                                        cur_col_next = cur_col_reg + COL_W'(1);
                                    end
                                    else
                                    begin
                                        // line feed, also on wrap at the last column
                                        if (byte_reg != BYTE_LF)
                                            cur_col_next = '0;
                                        if (cur_row_reg != ROW_W'(SCREEN_ROWS - 1))
                                            cur_row_next = cur_row_reg + ROW_W'(1);
                                        else
                                        begin
                                            if (used_reg < USED_W'(HISTORY_LINES))
                                            begin
                                                slot_sum = {1'b0, first_reg}
                                                         + (SLOT_W+1)'(used_reg);
                                                if (slot_sum >= (SLOT_W+1)'(HISTORY_LINES))
                                                    slot_sum = slot_sum
                                                             - (SLOT_W+1)'(HISTORY_LINES);
                                                slot_next = slot_sum[SLOT_W-1:0];
                                                used_lf   = used_reg + USED_W'(1);
                                                used_next = used_lf;
                                            end
                                            else
                                            begin
                                                slot_next = first_reg;
                                                if (first_reg == SLOT_W'(HISTORY_LINES - 1))
                                                    first_next = '0;
                                                else
                                                    first_next = first_reg + SLOT_W'(1);
                                            end
                                            if (voff_reg != '0 && voff_reg < used_lf)
                                                voff_next = voff_reg + USED_W'(1);
                                            sw_col_next = '0;
                                            state_next  = ST_SCROLL;
                                        end
                                    end
                                end
                            end
                        endcase
                    end

                    FUNC_VIEW_UP:
                    begin
                        lines_room = (USED_W+1)'(used_reg) - (USED_W+1)'(voff_reg);
                        off_sum    = (USED_W+1)'(voff_reg) + (USED_W+1)'(lines_reg);
                        if ((USED_W+1)'(lines_reg) > lines_room)
                            voff_next = used_reg;
                        else
                            voff_next = off_sum[USED_W-1:0];
                        moved_next = (voff_next != voff_reg);
                    end

                    FUNC_VIEW_DOWN:
                    begin
                        if ((USED_W+1)'(lines_reg) >= (USED_W+1)'(voff_reg))
                            voff_next = '0;
                        else
                            voff_next = USED_W'((USED_W+1)'(voff_reg) - (USED_W+1)'(lines_reg));
                        moved_next = (voff_next != voff_reg);
                    end

                    default:
                    begin
                        if (vrow_reg >= 8'(SCREEN_ROWS) || 9'(vcol_reg) >= 9'(SCREEN_COLUMNS))
                            blank_next = 1'b1;
                        else
                        begin
                            abs_line = (USED_W+1)'(used_reg) - (USED_W+1)'(voff_reg)
                                     + (USED_W+1)'(vrow_reg);
                            if (abs_line < (USED_W+1)'(used_reg))
                            begin
                                slot_sum = (SLOT_W+1)'(first_reg) + (SLOT_W+1)'(abs_line);
                                if (slot_sum >= (SLOT_W+1)'(HISTORY_LINES))
                                    slot_sum = slot_sum - (SLOT_W+1)'(HISTORY_LINES);
                                req.hist_re   = 1'b1;
                                req.hist_slot = slot_sum[SLOT_W-1:0];
                                req.hist_col  = vcol_reg[COL_W-1:0];
                            end
                            else
                            begin
                                abs_sum      = (ROW_W+1)'(abs_line - (USED_W+1)'(used_reg));
                                req.scr_re   = 1'b1;
                                req.scr_rrow = to_phys(abs_sum[ROW_W-1:0], top_reg);
                                req.scr_rcol = vcol_reg[COL_W-1:0];
                            end
                        end
                    end
                endcase
            end

            ST_CMD:
            begin
                state_next = ST_RESP;
                case (byte_reg)
                    CMD_SGR:
                    begin
                        if (cnt_reg == '0)
                            style_next = STYLE_DEFAULT;
                        else
                        begin
                            sgr_idx_next = '0;
                            state_next   = ST_SGR;
                        end
                    end
                    CMD_POS_H, CMD_POS_F:
                    begin
                        cur_row_next = ((num0 - 16'd1) < 16'(SCREEN_ROWS))
                                     ? ROW_W'(num0 - 16'd1) : ROW_W'(SCREEN_ROWS - 1);
                        cur_col_next = ((num1 - 16'd1) < 16'(SCREEN_COLUMNS))
                                     ? COL_W'(num1 - 16'd1) : COL_W'(SCREEN_COLUMNS - 1);
                    end
                    CMD_ED:
                    begin
                        if (mode_num == 16'd2)
                        begin
                            sw_row_next = '0;
                            sw_col_next = '0;
                            state_next  = ST_CLEAR;
                        end
                    end
                    CMD_LEFT:
                    begin
                        cur_col_next = (amount >= 16'(cur_col_reg)) ? '0
                                     : cur_col_reg - COL_W'(amount);
                    end
                    CMD_UP:
                    begin
                        cur_row_next = (amount >= 16'(cur_row_reg)) ? '0
                                     : cur_row_reg - ROW_W'(amount);
                    end
                    CMD_DOWN:
                    begin
                        cur_row_next = (amount >= 16'(SCREEN_ROWS) - 16'(cur_row_reg))
                                     ? ROW_W'(SCREEN_ROWS - 1) : cur_row_reg + ROW_W'(amount);
                    end
                    CMD_RIGHT:
                    begin
                        cur_col_next = (amount >= 16'(SCREEN_COLUMNS) - 16'(cur_col_reg))
                                     ? COL_W'(SCREEN_COLUMNS - 1) : cur_col_reg + COL_W'(amount);
                    end
                    CMD_EL:
                    begin
                        sw_row_next = cur_phys;
                        if (mode_num == 16'd1)
                        begin
                            sw_col_next  = '0;
                            sw_last_next = cur_col_reg;
                        end
                        else if (mode_num == 16'd2)
                        begin
                            sw_col_next  = '0;
                            sw_last_next = COL_W'(SCREEN_COLUMNS - 1);
                        end
                        else
                        begin
                            sw_col_next  = cur_col_reg;
                            sw_last_next = COL_W'(SCREEN_COLUMNS - 1);
                        end
                        state_next = ST_KCLR;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_SGR:
            begin
                style_next = sgr_apply(style_reg, nums_reg[sgr_idx_reg]);
                sgr_idx_next = sgr_idx_reg + NIDX_W'(1);
                if (CNT_W'(sgr_idx_reg) + CNT_W'(1) >= cnt_reg)
                    state_next = ST_RESP;
            end

            ST_SCROLL:
            begin
                // read top cell for history, blank it for the new bottom row
                req.scr_re    = 1'b1;
                req.scr_rrow  = top_reg;
                req.scr_rcol  = sw_col_reg;
                req.scr_we    = 1'b1;
                req.scr_wrow  = top_reg;
                req.scr_wcol  = sw_col_reg;
                req.hist_copy = 1'b1;
                req.hist_slot = slot_reg;
                req.hist_col  = sw_col_reg;
                sw_col_next   = sw_col_reg + COL_W'(1);
                if (sw_col_reg == COL_W'(SCREEN_COLUMNS - 1))
                begin
                    sw_col_next = '0;
                    top_next    = (top_reg == ROW_W'(SCREEN_ROWS - 1)) ? '0
                                : top_reg + ROW_W'(1);
                    state_next  = ST_RESP;
                end
            end

            ST_KCLR:
            begin
                req.scr_we   = 1'b1;
                req.scr_wrow = sw_row_reg;
                req.scr_wcol = sw_col_reg;
                sw_col_next  = sw_col_reg + COL_W'(1);
                if (sw_col_reg == sw_last_reg)
                    state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            func_reg  <= in_func;
            byte_reg  <= in_byte;
            lines_reg <= in_lines;
            vrow_reg  <= in_vrow;
            vcol_reg  <= in_vcol;
        end
        sw_last_reg <= sw_last_next;
        slot_reg    <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            pmode_reg   <= PM_NORMAL;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            style_reg   <= STYLE_DEFAULT;
            for (int i = 0; i < MAX_SEQUENCE_NUMBERS; i++)
            begin
                nums_reg[i] <= 16'd0;
            end
            cnt_reg     <= '0;
            acc_reg     <= 16'd0;
            seen_reg    <= 1'b0;
            first_reg   <= '0;
            used_reg    <= '0;
            voff_reg    <= '0;
            top_reg     <= '0;
            sw_row_reg  <= '0;
            sw_col_reg  <= '0;
            sgr_idx_reg <= '0;
            moved_reg   <= 1'b0;
            blank_reg   <= 1'b0;
            init_reg    <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            pmode_reg   <= pmode_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            style_reg   <= style_next;
            nums_reg    <= nums_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            seen_reg    <= seen_next;
            first_reg   <= first_next;
            used_reg    <= used_next;
            voff_reg    <= voff_next;
            top_reg     <= top_next;
            sw_row_reg  <= sw_row_next;
            sw_col_reg  <= sw_col_next;
            sgr_idx_reg <= sgr_idx_next;
            moved_reg   <= moved_next;
            blank_reg   <= blank_next;
            init_reg    <= init_next;
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("sequencer state not one-hot");

    a_view_in_history: assert property (@(posedge clk) disable iff (!rst_n)
        voff_reg <= used_reg) else $error("view offset beyond history");

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cur_row_reg < ROW_W'(SCREEN_ROWS) && cur_col_reg < COL_W'(SCREEN_COLUMNS))
        else $error("cursor off screen");

    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> !in_ready) else $error("input taken during reset clear");

    a_history_first_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg != $past(first_reg) |-> used_reg == USED_W'(HISTORY_LINES))
        else $error("history start moved before ring full");

endmodule

// ----- tb/sv/ansi_terminal_screen_engine_top_test.sv -----
`timescale 1ns / 100ps

module ansi_terminal_screen_engine_top_test;
    import ate_pkg::*;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int CELLS       = SCREEN_ROWS * SCREEN_COLUMNS;

    typedef enum int {PM_NORMAL, PM_ESCAPE, PM_CSI, PM_OSC, PM_OSC_ESCAPE, PM_SKIP_ONE} pmode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    ansi_terminal_screen_engine_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow terminal state
    logic [15:0] shadow_screen [CELLS];
    logic [15:0] shadow_history [HISTORY_LINES * SCREEN_COLUMNS];
    int          hist_first, hist_used, view_off, cur_row, cur_col;
    logic [7:0]  cur_style;
    pmode_t      pmode;
    int          seq_nums [MAX_SEQUENCE_NUMBERS];
    int          seq_count;
    logic [15:0] seq_acc;
    bit          seq_seen;

    result_t     pending_results [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;
    int          cycle_count = 0;

    function automatic void term_clear(int row, int first, int last);
        for (int c = first; c <= last && c < SCREEN_COLUMNS; c++)
            shadow_screen[row * SCREEN_COLUMNS + c] = '0;
    endfunction

    function automatic void term_line_feed();
        int slot;
        if (cur_row + 1 < SCREEN_ROWS)
        begin
            cur_row++;
            return;
        end
        if (hist_used < HISTORY_LINES)
        begin
            slot = (hist_first + hist_used) % HISTORY_LINES;
            hist_used++;
        end
        else
        begin
            slot = hist_first;
            hist_first = (hist_first + 1) % HISTORY_LINES;
        end
        for (int c = 0; c < SCREEN_COLUMNS; c++)
            shadow_history[slot * SCREEN_COLUMNS + c] = shadow_screen[c];
        // keep a scrolled-back view on the same lines
        if (view_off > 0 && view_off < hist_used)
            view_off++;
        for (int i = 0; i < CELLS - SCREEN_COLUMNS; i++)
            shadow_screen[i] = shadow_screen[i + SCREEN_COLUMNS];
        term_clear(SCREEN_ROWS - 1, 0, SCREEN_COLUMNS - 1);
    endfunction

    function automatic int param_or(int idx, int dflt);
        if (idx >= seq_count || seq_nums[idx] == 0)
            return dflt;
        return seq_nums[idx];
    endfunction

    function automatic void term_sgr();
        int p, fg, bg;
        if (seq_count == 0)
        begin
            cur_style = STYLE_DEFAULT;
            return;
        end
        for (int i = 0; i < seq_count; i++)
        begin
            p  = seq_nums[i];
            fg = cur_style[3:0];
            bg = cur_style[7:4];
            if (p == 0) begin fg = 7; bg = 0; end
            else if (p == 1 && fg < 8) fg += 8;
            else if (p == 22 && fg >= 8) fg -= 8;
            else if (p >= 30 && p <= 37) fg = p - 30;
            else if (p == 39) fg = 7;
            else if (p >= 40 && p <= 47) bg = p - 40;
            else if (p == 49) bg = 0;
            else if (p >= 90 && p <= 97) fg = p - 82;
            else if (p >= 100 && p <= 107) bg = p - 92;
            cur_style = {bg[3:0], fg[3:0]};
        end
    endfunction

    function automatic void term_command(logic [7:0] cmd);
        int amount, r, c;
        int mode;
        mode = (seq_count == 0) ? 0 : seq_nums[0];
        case (cmd)
            CMD_SGR: term_sgr();
            CMD_POS_H, CMD_POS_F:
            begin
                r = param_or(0, 1) - 1;
                c = param_or(1, 1) - 1;
                cur_row = (r < SCREEN_ROWS) ? r : SCREEN_ROWS - 1;
                cur_col = (c < SCREEN_COLUMNS) ? c : SCREEN_COLUMNS - 1;
            end
            CMD_ED:
                if (mode == 2)
                    for (int i = 0; i < CELLS; i++) shadow_screen[i] = '0;
            CMD_LEFT:
            begin
                amount = param_or(0, 1);
                cur_col = (amount >= cur_col) ? 0 : cur_col - amount;
            end
            CMD_UP:
            begin
                amount = param_or(0, 1);
                cur_row = (amount >= cur_row) ? 0 : cur_row - amount;
            end
            CMD_DOWN:
            begin
                amount = param_or(0, 1);
                cur_row = (amount >= SCREEN_ROWS - cur_row) ? SCREEN_ROWS - 1
                                                           : cur_row + amount;
            end
            CMD_RIGHT:
            begin
                amount = param_or(0, 1);
                cur_col = (amount >= SCREEN_COLUMNS - cur_col) ? SCREEN_COLUMNS - 1
                                                              : cur_col + amount;
            end
            CMD_EL:
                if (mode == 1) term_clear(cur_row, 0, cur_col);
                else if (mode == 2) term_clear(cur_row, 0, SCREEN_COLUMNS - 1);
                else term_clear(cur_row, cur_col, SCREEN_COLUMNS - 1);
            default: ;
        endcase
    endfunction

    function automatic void term_feed(logic [7:0] b);
        case (pmode)
            PM_ESCAPE:
            begin
                if (b == BYTE_LBRACK)
                begin
                    pmode = PM_CSI;
                    foreach (seq_nums[i]) seq_nums[i] = 0;
                    seq_count = 0;
                    seq_acc   = '0;
                    seq_seen  = 1'b0;
                end
                else if (b == BYTE_RBRACK) pmode = PM_OSC;
                else if (b == BYTE_LPAREN || b == BYTE_RPAREN) pmode = PM_SKIP_ONE;
                else pmode = PM_NORMAL;
                return;
            end
            PM_OSC:
            begin
                if (b == BYTE_BEL) pmode = PM_NORMAL;
                else if (b == BYTE_ESC) pmode = PM_OSC_ESCAPE;
                return;
            end
            PM_OSC_ESCAPE:
            begin
                pmode = (b == BYTE_BSLASH || b == BYTE_BEL) ? PM_NORMAL : PM_OSC;
                return;
            end
            PM_SKIP_ONE:
            begin
                pmode = PM_NORMAL;
                return;
            end
            PM_CSI:
            begin
                if (b >= BYTE_ZERO && b <= BYTE_NINE)
                begin
                    seq_seen = 1'b1;
                    seq_acc  = 16'(32'(seq_acc) * 10 + 32'(b - BYTE_ZERO));
                end
                else if (b == BYTE_SEMI)
                begin
                    if (seq_count < MAX_SEQUENCE_NUMBERS)
                    begin
                        seq_nums[seq_count] = seq_seen ? int'(seq_acc) : 0;
                        seq_count++;
                    end
                    seq_acc  = '0;
                    seq_seen = 1'b0;
                end
                else if (b >= BYTE_FINAL_LO && b <= BYTE_TILDE)
                begin
                    if (seq_count < MAX_SEQUENCE_NUMBERS && (seq_seen || seq_count == 0))
                    begin
                        seq_nums[seq_count] = seq_seen ? int'(seq_acc) : 0;
                        seq_count++;
                    end
                    term_command(b);
                    pmode = PM_NORMAL;
                end
                return;
            end
            default: ;
        endcase
        pmode = PM_NORMAL;
        if (b == BYTE_ESC) pmode = PM_ESCAPE;
        else if (b == BYTE_CR) cur_col = 0;
        else if (b == BYTE_LF) term_line_feed();
        else if (b == BYTE_BS)
        begin
            if (cur_col > 0) cur_col--;
        end
        else if (b == BYTE_TAB)
        begin
            cur_col = (cur_col + 8) & ~7;
            if (cur_col >= SCREEN_COLUMNS) cur_col = SCREEN_COLUMNS - 1;
        end
        else if (b >= BYTE_SPACE && b <= BYTE_TILDE)
        begin
            shadow_screen[cur_row * SCREEN_COLUMNS + cur_col] = {cur_style, b};
            if (cur_col + 1 < SCREEN_COLUMNS) cur_col++;
            else
            begin
                cur_col = 0;
                term_line_feed();
            end
        end
    endfunction

    function automatic logic [15:0] view_cell(int row, int col);
        int line;
        if (row >= SCREEN_ROWS || col >= SCREEN_COLUMNS)
            return '0;
        line = hist_used - view_off + row;
        if (line < hist_used)
            return shadow_history[((hist_first + line) % HISTORY_LINES) * SCREEN_COLUMNS + col];
        line -= hist_used;
        return (line < SCREEN_ROWS) ? shadow_screen[line * SCREEN_COLUMNS + col] : '0;
    endfunction

    // Advance the shadow terminal by one request and return the expected word
    function automatic result_t terminal_step(logic [1:0] f, logic [7:0] b, logic [8:0] lines,
                                              logic [7:0] row, logic [7:0] col);
        result_t res;
        int prior;
        prior = view_off;
        res = '0;
        case (f)
            FUNC_FEED: term_feed(b);
            FUNC_VIEW_UP:
            begin
                view_off = (lines > hist_used - view_off) ? hist_used : view_off + lines;
                res.view_moved = (view_off != prior);
            end
            FUNC_VIEW_DOWN:
            begin
                view_off = (lines >= view_off) ? 0 : view_off - lines;
                res.view_moved = (view_off != prior);
            end
            default: {res.cell_style, res.cell_character} = view_cell(row, col);
        endcase
        res.cursor_row_now    = cur_row[ROW_W-1:0];
        res.cursor_column_now = cur_col[COL_W-1:0];
        return res;
    endfunction

    // Send one request word, predict its result once accepted
    task automatic send_request(logic [1:0] f, logic [7:0] b, logic [8:0] lines,
                                logic [7:0] row, logic [7:0] col);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {7'b0, col, row, lines, b};
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(terminal_step(f, b, lines, row, col));
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Byte feed; unused fields carry random bits
    task automatic send_byte(logic [7:0] b);
        send_request(FUNC_FEED, b, 9'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_number(int n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_csi(int params [$], logic [7:0] final_byte);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LBRACK);
        foreach (params[i])
        begin
            if (i > 0) send_byte(BYTE_SEMI);
            if (params[i] >= 0) send_number(params[i]);
        end
        send_byte(final_byte);
    endtask

    task automatic send_scroll(logic [1:0] f, int lines);
        send_request(f, 8'($urandom), 9'(lines), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_read(int row, int col);
        send_request(FUNC_READ, 8'($urandom), 9'($urandom), 8'(row), 8'(col));
    endtask

    // Result checker: oldest expectation against each accepted word
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.cell_character)
                begin
                    $error("cell_character exp %h got %h", want.cell_character, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tdata[15:8] !== want.cell_style)
                begin
                    $error("cell_style exp %h got %h", want.cell_style, m_tdata[15:8]);
                    error_count++;
                end
                if (m_tdata[16] !== want.view_moved)
                begin
                    $error("view_moved exp %b got %b", want.view_moved, m_tdata[16]);
                    error_count++;
                end
                if (m_tdata[21:17] !== want.cursor_row_now)
                begin
                    $error("cursor_row_now exp %0d got %0d", want.cursor_row_now, m_tdata[21:17]);
                    error_count++;
                end
                if (m_tdata[28:22] !== want.cursor_column_now)
                begin
                    $error("cursor_column_now exp %0d got %0d",
                           want.cursor_column_now, m_tdata[28:22]);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        int p [$];
        send_byte(BYTE_SPACE);
        send_byte(BYTE_TILDE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(BYTE_TAB);
        send_byte(BYTE_BS);
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        p = '{1, 31, 44};
        send_csi(p, CMD_SGR);
        send_byte(8'h41);
        p = '{99, 999};
        send_csi(p, CMD_POS_H);        // clamped to the bottom-right corner
        send_byte(8'h5A);              // wraps at the last column and scrolls
        send_read(0, 0);
        send_read(255, 255);           // outside the screen reads blank
        send_scroll(FUNC_VIEW_UP, 256);
        send_read(0, 0);
        send_scroll(FUNC_VIEW_DOWN, 256);
        send_scroll(FUNC_VIEW_DOWN, 0);
        send_byte(BYTE_ESC);
        send_byte(BYTE_LPAREN);
        send_byte(8'h42);              // skipped charset byte
        p = '{2};
        send_csi(p, CMD_ED);
    endtask

    // Fill the history ring past its size, with the view held back at times
    task automatic test_history_ring();
        int p [$];
        p = '{24};
        send_csi(p, CMD_POS_H);
        for (int i = 0; i < HISTORY_LINES + 40; i++)
        begin
            send_byte(8'h21 + 8'(i % 90));
            send_byte(BYTE_LF);
            if (i % 37 == 5) send_scroll(FUNC_VIEW_UP, $urandom_range(1, 30));
            if (i % 37 == 20) send_read($urandom_range(0, 3), 0);
            if (i % 53 == 0) send_scroll(FUNC_VIEW_DOWN, 256);
        end
        send_scroll(FUNC_VIEW_UP, 256);
        send_read(0, 0);
        send_read(SCREEN_ROWS - 1, SCREEN_COLUMNS - 1);
        send_scroll(FUNC_VIEW_UP, 1);
        send_scroll(FUNC_VIEW_DOWN, 256);
    endtask

    task automatic random_csi();
        int p [$];
        int n;
        logic [7:0] fin;
        logic [7:0] finals [12];
        finals = '{CMD_SGR, CMD_SGR, CMD_POS_H, CMD_POS_F, CMD_UP, CMD_DOWN,
                   CMD_RIGHT, CMD_LEFT, CMD_ED, CMD_EL, CMD_SGR, CMD_EL};
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 5))
                0: p.push_back(-1);                      // empty parameter
                1: p.push_back($urandom_range(0, 2));
                2: p.push_back($urandom_range(0, 107));
                3: p.push_back($urandom_range(0, 999999)); // accumulator wrap
                default: p.push_back($urandom_range(0, 30));
            endcase
        fin = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8'h40, 8'h7E))
                                          : finals[$urandom_range(0, 11)];
        // whole-screen erase is slow; keep it rare
        if (fin == CMD_ED && $urandom_range(0, 3) != 0) fin = CMD_EL;
        send_csi(p, fin);
    endtask

    task automatic random_burst(int count);
        for (int k = 0; k < count; k++)
        begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
            else if (pick < 47)
                case ($urandom_range(0, 3))
                    0: send_byte(BYTE_CR);
                    1: send_byte(BYTE_LF);
                    2: send_byte(BYTE_BS);
                    default: send_byte(BYTE_TAB);
                endcase
            else if (pick < 65)
                random_csi();
            else if (pick < 69)
            begin
                send_byte(BYTE_ESC);
                send_byte(BYTE_RBRACK);
                repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
                if ($urandom_range(0, 1)) send_byte(BYTE_BEL);
                else
                begin
                    send_byte(BYTE_ESC);
                    send_byte($urandom_range(0, 1) ? BYTE_BSLASH : 8'($urandom));
                    send_byte(BYTE_BEL);
                end
            end
            else if (pick < 72)
            begin
                send_byte(BYTE_ESC);
                send_byte($urandom_range(0, 2) == 0 ? 8'($urandom)
                          : ($urandom_range(0, 1) ? BYTE_LPAREN : BYTE_RPAREN));
                send_byte(8'($urandom));
            end
            else if (pick < 80)
                send_scroll($urandom_range(0, 1) ? FUNC_VIEW_UP : FUNC_VIEW_DOWN,
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 256)
                                                      : $urandom_range(0, 8));
            else if (pick < 94)
                send_read($urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                    : $urandom_range(0, SCREEN_ROWS - 1),
                          $urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                    : $urandom_range(0, SCREEN_COLUMNS - 1));
            else
                send_byte(8'($urandom));
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  random_burst(60);
        send_idle_pct = 49; recv_stall_pct = 0;  random_burst(60);
        send_idle_pct = 0;  recv_stall_pct = 49; random_burst(60);
        send_idle_pct = 12; recv_stall_pct = 12; random_burst(60);
        send_idle_pct = 0;  recv_stall_pct = 0;
    endtask

    // Long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        hold_off_cycles = 500;
        random_burst(20);
    endtask

    initial
    begin
        int waited;
        // screen starts blank with the default style
        foreach (shadow_screen[i]) shadow_screen[i] = '0;
        cur_style = STYLE_DEFAULT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_history_ring();
        test_random_phases();
        test_backpressure();
        @(posedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 100_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ate_pkg.sv
rtl/ate_store.sv
rtl/ate_ctrl.sv
rtl/ansi_terminal_screen_engine_top.sv
tb/sv/ansi_terminal_screen_engine_top_test.sv
